>>> rtl/rtnh_pkg.sv
package rtnh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DIST_WIDTH      = 32;
    localparam int CFG_WIDTH       = 32;
    localparam int ADDR_WIDTH      = 5;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_MAX_DIST = 3'd6;
    localparam logic [2:0] REG_DET_EPS  = 3'd7;

    // multiply-accumulate step codes
    typedef enum logic [4:0] {
        OP_NONE,
        OP_P_X0, OP_P_X1, OP_P_Y0, OP_P_Y1, OP_P_Z0, OP_P_Z1,
        OP_Q_X0, OP_Q_X1, OP_Q_Y0, OP_Q_Y1, OP_Q_Z0, OP_Q_Z1,
        OP_DET0, OP_DET1, OP_DET2,
        OP_UN0, OP_UN1, OP_UN2,
        OP_VN0, OP_VN1, OP_VN2,
        OP_TN0, OP_TN1, OP_TN2
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIX,
        ST_CHECK,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        mac_op_t op;
        logic    hi;
        logic    fix_sign;
        logic    div_start;
        logic    div_step;
        logic    commit;
    } cmd_t;

    typedef struct packed {
        logic pass;
        logic div_last;
        logic closer;
    } sts_t;

endpackage

>>> rtl/rtnh_datapath.sv
module rtnh_datapath
    import rtnh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] vin [9],
    input  logic signed [COORD_WIDTH-1:0] org [3],
    input  logic signed [COORD_WIDTH-1:0] dir [3],
    input  logic [DIST_WIDTH-1:0]         nearest,
    input  logic [CFG_WIDTH-1:0]          det_epsilon,
    input  cmd_t                          cmd,
    output sts_t                          sts,
    output logic [DIST_WIDTH-1:0]         quotient
);

    // edges: COORD+1 bits; cross: 2C+4; dots: 3C+8
    localparam int EW = COORD_WIDTH + 1;
    localparam int CW = 2 * EW + 2;
    localparam int DW = CW + EW + 3;
    localparam int LB = EW + 1;
    localparam int NW = DW + FRAC_BITS;
    localparam int SW = DW + DIST_WIDTH;
    localparam int QB = $clog2(DIST_WIDTH);

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] t_reg  [3];
    logic signed [EW-1:0] d_reg  [3];
    logic signed [CW-1:0] p_reg  [3];
    logic signed [CW-1:0] q_reg  [3];
    logic signed [DW-1:0] acc_reg, det_reg, un_reg, vn_reg, tn_reg;
    logic signed [EW-1:0] op_a;
    logic signed [EW+1:0] op_b;
    logic signed [CW-1:0] wsel;
    logic dot_w;
    logic signed [2*EW+1:0] prod;
    logic signed [DW-1:0] term_w;
    logic [NW-1:0] rem_reg;
    logic [SW-1:0] dsh_reg;
    logic [DIST_WIDTH-1:0] quo_reg;
    logic [QB-1:0] bit_reg;
    logic signed [DW:0] eps_w;
    logic [NW-1:0] num_w;
    logic take_w;
    logic neg_w;

    // select operands of the shared multiplier; split dot-product weights in halves
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        wsel  = '0;
        dot_w = 1'b0;
        case (cmd.op)
            OP_P_X0: begin op_a = d_reg[1]; op_b = (EW + 2)'(e2_reg[2]); end
            OP_P_X1: begin op_a = d_reg[2]; op_b = (EW + 2)'(e2_reg[1]); end
            OP_P_Y0: begin op_a = d_reg[2]; op_b = (EW + 2)'(e2_reg[0]); end
            OP_P_Y1: begin op_a = d_reg[0]; op_b = (EW + 2)'(e2_reg[2]); end
            OP_P_Z0: begin op_a = d_reg[0]; op_b = (EW + 2)'(e2_reg[1]); end
            OP_P_Z1: begin op_a = d_reg[1]; op_b = (EW + 2)'(e2_reg[0]); end
            OP_Q_X0: begin op_a = t_reg[1]; op_b = (EW + 2)'(e1_reg[2]); end
            OP_Q_X1: begin op_a = t_reg[2]; op_b = (EW + 2)'(e1_reg[1]); end
            OP_Q_Y0: begin op_a = t_reg[2]; op_b = (EW + 2)'(e1_reg[0]); end
            OP_Q_Y1: begin op_a = t_reg[0]; op_b = (EW + 2)'(e1_reg[2]); end
            OP_Q_Z0: begin op_a = t_reg[0]; op_b = (EW + 2)'(e1_reg[1]); end
            OP_Q_Z1: begin op_a = t_reg[1]; op_b = (EW + 2)'(e1_reg[0]); end
            OP_DET0: begin op_a = e1_reg[0]; wsel = p_reg[0]; dot_w = 1'b1; end
            OP_DET1: begin op_a = e1_reg[1]; wsel = p_reg[1]; dot_w = 1'b1; end
            OP_DET2: begin op_a = e1_reg[2]; wsel = p_reg[2]; dot_w = 1'b1; end
            OP_UN0:  begin op_a = t_reg[0];  wsel = p_reg[0]; dot_w = 1'b1; end
            OP_UN1:  begin op_a = t_reg[1];  wsel = p_reg[1]; dot_w = 1'b1; end
            OP_UN2:  begin op_a = t_reg[2];  wsel = p_reg[2]; dot_w = 1'b1; end
            OP_VN0:  begin op_a = d_reg[0];  wsel = q_reg[0]; dot_w = 1'b1; end
            OP_VN1:  begin op_a = d_reg[1];  wsel = q_reg[1]; dot_w = 1'b1; end
            OP_VN2:  begin op_a = d_reg[2];  wsel = q_reg[2]; dot_w = 1'b1; end
            OP_TN0:  begin op_a = e2_reg[0]; wsel = q_reg[0]; dot_w = 1'b1; end
            OP_TN1:  begin op_a = e2_reg[1]; wsel = q_reg[1]; dot_w = 1'b1; end
            OP_TN2:  begin op_a = e2_reg[2]; wsel = q_reg[2]; dot_w = 1'b1; end
            default: ;
        endcase
        if (dot_w)
            op_b = cmd.hi ? (EW + 2)'(signed'(wsel[CW-1:LB]))
                          : signed'({1'b0, wsel[LB-1:0]});
    end

    assign prod   = op_a * op_b;
    assign term_w = cmd.hi ? (DW'(prod) <<< LB) : DW'(prod);

    // acceptance tests on the sign-corrected results, divide-end and nearer flags
    assign eps_w = (DW + 1)'(signed'({1'b0, det_epsilon})) <<< (2 * FRAC_BITS);
    assign num_w = NW'(tn_reg) << FRAC_BITS;
    always_comb
    begin
        sts.pass = ((DW + 1)'(det_reg) > eps_w)
                && (un_reg >= 0) && (un_reg <= det_reg)
                && (vn_reg >= 0)
                && ((DW + 1)'(un_reg) + (DW + 1)'(vn_reg) <= (DW + 1)'(det_reg))
                && (tn_reg >= 0)
                && (SW'(num_w) < (SW'(unsigned'(det_reg)) << DIST_WIDTH));
        sts.div_last = (bit_reg == '0);
        sts.closer   = (quo_reg < nearest);
    end

    // restoring divide, one quotient bit a step
    assign take_w = (dsh_reg <= SW'(rem_reg));
    assign neg_w  = det_reg < 0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(vin[3 + i]) - EW'(vin[i]);
                e2_reg[i] <= EW'(vin[6 + i]) - EW'(vin[i]);
                t_reg[i]  <= EW'(org[i]) - EW'(vin[i]);
                d_reg[i]  <= EW'(dir[i]);
            end
        end
        case (cmd.op)
            OP_P_X0: acc_reg <= DW'(prod);
            OP_P_X1: p_reg[0] <= CW'(acc_reg - DW'(prod));
            OP_P_Y0: acc_reg <= DW'(prod);
            OP_P_Y1: p_reg[1] <= CW'(acc_reg - DW'(prod));
            OP_P_Z0: acc_reg <= DW'(prod);
            OP_P_Z1: p_reg[2] <= CW'(acc_reg - DW'(prod));
            OP_Q_X0: acc_reg <= DW'(prod);
            OP_Q_X1: q_reg[0] <= CW'(acc_reg - DW'(prod));
            OP_Q_Y0: acc_reg <= DW'(prod);
            OP_Q_Y1: q_reg[1] <= CW'(acc_reg - DW'(prod));
            OP_Q_Z0: acc_reg <= DW'(prod);
            OP_Q_Z1: q_reg[2] <= CW'(acc_reg - DW'(prod));
            OP_DET0, OP_UN0, OP_VN0, OP_TN0:
                acc_reg <= cmd.hi ? acc_reg + term_w : term_w;
            OP_DET1, OP_UN1, OP_VN1, OP_TN1: acc_reg <= acc_reg + term_w;
            OP_DET2:
            begin
                if (cmd.hi)
                    det_reg <= acc_reg + term_w;
                else
                    acc_reg <= acc_reg + term_w;
            end
            OP_UN2:
            begin
                if (cmd.hi)
                    un_reg <= acc_reg + term_w;
                else
                    acc_reg <= acc_reg + term_w;
            end
            OP_VN2:
            begin
                if (cmd.hi)
                    vn_reg <= acc_reg + term_w;
                else
                    acc_reg <= acc_reg + term_w;
            end
            OP_TN2:
            begin
                if (cmd.hi)
                    tn_reg <= acc_reg + term_w;
                else
                    acc_reg <= acc_reg + term_w;
            end
            default: ;
        endcase
        // flip all four when the determinant is negative
        if (cmd.fix_sign && neg_w)
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
        if (cmd.div_start)
        begin
            rem_reg <= num_w;
            dsh_reg <= SW'(unsigned'(det_reg)) << (DIST_WIDTH - 1);
            quo_reg <= '0;
            bit_reg <= QB'(DIST_WIDTH - 1);
        end
        else if (cmd.div_step)
        begin
            if (take_w)
                rem_reg <= NW'(SW'(rem_reg) - dsh_reg);
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[DIST_WIDTH-2:0], take_w};
            bit_reg <= bit_reg - 1'b1;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> rtl/rtnh_ctrl.sv
module rtnh_ctrl
    import rtnh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic last_in,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_ready,
    output logic emit
);

    state_t  state_reg, state_next;
    mac_op_t op_reg, op_next;
    logic    hi_reg, hi_next;
    logic    last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
            hi_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            hi_reg    <= hi_next;
            last_reg  <= last_next;
        end
    end

    // sequence the shared multiplier, checks and divider
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        hi_next    = hi_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    last_next  = last_in;
                    op_next    = OP_P_X0;
                    hi_next    = 1'b0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.op = op_reg;
                cmd.hi = hi_reg;
                // dot product terms take a low and a high half
                if ((op_reg inside {[OP_DET0:OP_TN2]}) && !hi_reg)
                    hi_next = 1'b1;
                else
                begin
                    hi_next = 1'b0;
                    if (op_reg == OP_TN2)
                    begin
                        op_next    = OP_NONE;
                        state_next = ST_FIX;
                    end
                    else
                        op_next = mac_op_t'(op_reg + 1'b1);
                end
            end
            ST_FIX:
            begin
                cmd.fix_sign = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.pass)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // keep the hit only when strictly nearer
                if (sts.closer)
                    cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (!out_busy)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/ray_triangle_nearest_hit.sv
// Channel  | handshake           | payload
// in       | in_valid/in_ready   | a_x..c_z, last_triangle
// out      | out_valid/out_ready | hit, hit_distance
// cfg      | APB psel/penable    | origin, dir, max_distance, det_epsilon
// One triangle runs from accept to accept through 36 steps on one shared
// multiplier about as wide as a coordinate (dot products in two halves), a
// sign fix and a check; a triangle that passes then takes 32 divide steps
// and a commit if nearer. A new triangle is taken only once the last is through.
// A result waits in an output register; the next run goes on meanwhile and
// stalls only if its own result finds that register still full.
// Reset loads the register defaults and clears any stored hit.
module ray_triangle_nearest_hit
    import rtnh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    input  logic                          last_triangle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [DIST_WIDTH-1:0]         hit_distance,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_WIDTH-1:0]         paddr,
    input  logic [CFG_WIDTH-1:0]          pwdata,
    output logic [CFG_WIDTH-1:0]          prdata,
    output logic                          pready
);

    logic [CFG_WIDTH-1:0] cfg_reg [8];
    logic [DIST_WIDTH-1:0] nearest_reg;
    logic any_hit_reg;
    logic out_valid_reg, hit_reg;
    logic [DIST_WIDTH-1:0] dist_reg;
    logic wr_en, in_fire, emit;
    logic [2:0] widx;
    logic signed [COORD_WIDTH-1:0] vin [9];
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [COORD_WIDTH-1:0] dir [3];
    logic [DIST_WIDTH-1:0] quotient;
    cmd_t cmd;
    sts_t sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign widx    = paddr[4:2];
    assign prdata  = cfg_reg[widx];
    assign in_fire = in_valid && in_ready;

    assign vin = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
    for (genvar i = 0; i < 3; i++)
    begin : g_ray
        assign org[i] = COORD_WIDTH'(signed'(cfg_reg[REG_ORIGIN_X + i]));
        assign dir[i] = COORD_WIDTH'(signed'(cfg_reg[REG_DIR_X + i]));
    end

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (3'(i) == REG_DIR_X)
                    cfg_reg[i] <= CFG_WIDTH'(1) << FRAC_BITS;
                else if (3'(i) == REG_MAX_DIST)
                    cfg_reg[i] <= '1;
                else
                    cfg_reg[i] <= '0;
            end
        end
        else if (wr_en)
            cfg_reg[widx] <= pwdata;
    end

    // track the running nearest hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_reg <= '1;
            any_hit_reg <= 1'b0;
        end
        else if (emit)
        begin
            nearest_reg <= cfg_reg[REG_MAX_DIST];
            any_hit_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            nearest_reg <= quotient;
            any_hit_reg <= 1'b1;
        end
        else if (wr_en && widx == REG_MAX_DIST && !any_hit_reg)
            nearest_reg <= pwdata;
    end

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hit_reg  <= any_hit_reg;
            dist_reg <= any_hit_reg ? nearest_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;

    rtnh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .last_in  (last_triangle),
        .out_busy (out_valid_reg && !out_ready),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready),
        .emit     (emit)
    );

    rtnh_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .vin         (vin),
        .org         (org),
        .dir         (dir),
        .nearest     (nearest_reg),
        .det_epsilon (cfg_reg[REG_DET_EPS]),
        .cmd         (cmd),
        .sts         (sts),
        .quotient    (quotient)
    );

endmodule

>>> rtl/rtnh_checker.sv
module rtnh_checker
    import rtnh_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  hit,
    input logic [DIST_WIDTH-1:0] hit_distance,
    input logic                  pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_distance))
        else $error("result dropped while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0)
        else $error("miss carries nonzero distance");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind ray_triangle_nearest_hit rtnh_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_distance (hit_distance),
    .pready       (pready)
);
